// ===== hdl/layered_depth_sort_list_defines.svh =====
// Assertion macros shared by the layered depth-sort list RTL.
// Needs a clk and an active-low rst_n in the scope where the macros are used.
`ifndef LAYERED_DEPTH_SORT_LIST_DEFINES_SVH
`define LAYERED_DEPTH_SORT_LIST_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define LDSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define LDSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ldsl_pkg.sv =====
`timescale 1ns / 1ps
// Types and codes for the layered depth-sort list.
// No dependencies.
package ldsl_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DRAIN  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ENTRY    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } ctrl_state_t;

  // One list record; top is pos_y minus half the height, 13-bit signed.
  typedef struct packed {
    logic [3:0]         layer;
    logic signed [12:0] top;
    logic [7:0]         sprite;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [11:0]        x;
    logic [11:0]        y;
    logic [9:0]         width;
    logic [9:0]         height;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    latch;
    logic    insert;
    logic    clear;
    logic    drain_start;
    logic    rotate;
    logic    emit_status;
    logic    emit_entry;
    status_t code;
  } ldsl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       full;
    logic       empty;
    logic       drain_emit;
    logic       drain_end;
  } ldsl_sts_t;

endpackage

// ===== hdl/ldsl_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the layered depth-sort list: handshakes and datapath commands.
// Depends on ldsl_pkg.
module ldsl_ctrl
  import ldsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  ldsl_sts_t sts,
  output ldsl_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_INSERTED;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.mode)
          MODE_INSERT: begin
            if (out_free) begin
              cmd.emit_status = 1'b1;
              if (sts.full) begin
                cmd.code = ST_FULL;
              end else begin
                cmd.insert = 1'b1;
                cmd.code   = ST_INSERTED;
              end
              state_nxt = S_IDLE;
            end
          end
          MODE_CLEAR: begin
            if (out_free) begin
              cmd.clear       = 1'b1;
              cmd.emit_status = 1'b1;
              cmd.code        = ST_CLEARED;
              state_nxt       = S_IDLE;
            end
          end
          MODE_DRAIN: begin
            if (!sts.empty) begin
              cmd.drain_start = 1'b1;
              state_nxt       = S_DRAIN;
            end else if (out_free) begin
              cmd.emit_status = 1'b1;
              cmd.code        = ST_EMPTY;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;  // unused mode: no result
          end
        endcase
      end
      S_DRAIN: begin
        // slots past the count rotate without a result
        if (!sts.drain_emit || out_free) begin
          cmd.rotate     = 1'b1;
          cmd.emit_entry = sts.drain_emit;
          if (sts.drain_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit_status || cmd.emit_entry) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ===== hdl/ldsl_datapath.sv =====
`timescale 1ns / 1ps
// Sorted cell row, fill count, drain counter and result registers.
// Depends on ldsl_pkg and layered_depth_sort_list_defines.svh.
`include "layered_depth_sort_list_defines.svh"
module ldsl_datapath
  import ldsl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ldsl_cmd_t          cmd,
  output ldsl_sts_t          sts,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_sprite_id,
  input  logic [3:0]         in_draw_layer,
  input  logic [5:0]         in_sheet_col,
  input  logic [5:0]         in_sheet_row,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [9:0]         in_width,
  input  logic [9:0]         in_height,
  output logic [2:0]         out_status,
  output logic [7:0]         out_sprite,
  output logic [3:0]         out_layer,
  output logic [5:0]         out_col,
  output logic [5:0]         out_row,
  output logic signed [11:0] out_x,
  output logic signed [11:0] out_y,
  output logic [9:0]         out_width,
  output logic [9:0]         out_height,
  output logic               out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  entry_t              cells_r [CAPACITY];
  entry_t              new_r;
  logic [1:0]          mode_r;
  logic [CW-1:0]       count_r;
  logic [IW-1:0]       idx_r;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] ins;
  logic                drain_last;
  status_t             status_r;
  entry_t              res_r;
  logic                last_r;

  // Latch the request; the top edge is worked out here, off the compare path.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r        <= in_mode;
      new_r.layer   <= in_draw_layer;
      new_r.top     <= $signed({in_pos_y[11], in_pos_y}) - $signed({4'b0, in_height[9:1]});
      new_r.sprite  <= in_sprite_id;
      new_r.col     <= in_sheet_col;
      new_r.row     <= in_sheet_row;
      new_r.x       <= in_pos_x;
      new_r.y       <= in_pos_y;
      new_r.width   <= in_width;
      new_r.height  <= in_height;
    end
  end

  // Each cell compares its key with the new one; ins marks cells that take
  // the new record or their left neighbor.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      gt[k]  = (new_r.layer < cells_r[k].layer) ||
               ((new_r.layer == cells_r[k].layer) && (new_r.top < cells_r[k].top));
      ins[k] = ((CW'(k) < count_r) && gt[k]) || (CW'(k) == count_r);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int NEXT = (g + 1) % CAPACITY;
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && ins[g]) begin
          cells_r[g] <= new_r;
        end else if (cmd.rotate) begin
          cells_r[g] <= cells_r[NEXT];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.insert && ins[g]) begin
          cells_r[g] <= ins[g-1] ? cells_r[g-1] : new_r;
        end else if (cmd.rotate) begin
          cells_r[g] <= cells_r[NEXT];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.insert) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.drain_start) begin
        idx_r <= '0;
      end else if (cmd.rotate) begin
        idx_r <= (idx_r == IW'(CAPACITY - 1)) ? '0 : idx_r + IW'(1);
      end
    end
  end

  assign drain_last     = (CW'(idx_r) + CW'(1)) == count_r;
  assign sts.mode       = mode_r;
  assign sts.full       = (count_r == CW'(CAPACITY));
  assign sts.empty      = (count_r == '0);
  assign sts.drain_emit = (CW'(idx_r) < count_r);
  assign sts.drain_end  = (idx_r == IW'(CAPACITY - 1));

  // Result register; the head cell is the next entry in drain order.
  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      status_r <= cmd.code;
      res_r    <= '0;
      last_r   <= 1'b1;
    end else if (cmd.emit_entry) begin
      status_r <= ST_ENTRY;
      res_r    <= cells_r[0];
      last_r   <= drain_last;
    end
  end

  assign out_status = status_r;
  assign out_sprite = res_r.sprite;
  assign out_layer  = res_r.layer;
  assign out_col    = res_r.col;
  assign out_row    = res_r.row;
  assign out_x      = res_r.x;
  assign out_y      = res_r.y;
  assign out_width  = res_r.width;
  assign out_height = res_r.height;
  assign out_last   = last_r;

  `LDSL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")
  `LDSL_ASSERT_NEXT(a_clear_empties, cmd.clear, count_r == '0, "clear left entries behind")
  `LDSL_ASSERT_NEXT(a_insert_grows, cmd.insert && !cmd.clear, count_r == $past(count_r) + CW'(1), "insert did not grow the list")
  `LDSL_ASSERT_NOW(a_no_insert_full, cmd.insert, !sts.full, "insert into a full list")

endmodule

// ===== hdl/layered_depth_sort_list.sv =====
`timescale 1ns / 1ps
// Layered depth-sort list: an insert / clear is latched in S_IDLE and its result
// registered from S_EXEC when the output is free; the next item waits. A drain
// rotates the cell row once around in S_DRAIN, one entry per cycle, stalls aside.
// Reset (rst_n low, synchronous) empties the list; cell contents stay undefined.
// Depends on ldsl_pkg, ldsl_ctrl and ldsl_datapath.
//
// The list is a row of CAPACITY cells kept sorted by (layer, top edge). An insert
// compares the new key against every cell at once; cells at and after the first
// strictly greater key shift right by one and the gap takes the new record, so
// equal keys keep arrival order. A full list drops the insert and reports full.
//
// A drain rotates the row toward the head: the head cell goes out as a result and
// wraps to the tail. After CAPACITY rotations the row is back where it started,
// so the list survives the drain. Only the first count steps produce a transfer,
// the final one flagged with out_last. An empty list answers with one status.
//
// The result register parts the two channels: a new item transfers in while the
// previous result still waits on out_stall.
module layered_depth_sort_list
  import ldsl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_sprite_id,
  input  logic [3:0]         in_draw_layer,
  input  logic [5:0]         in_sheet_col,
  input  logic [5:0]         in_sheet_row,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [9:0]         in_width,
  input  logic [9:0]         in_height,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [7:0]         out_sprite,
  output logic [3:0]         out_layer,
  output logic [5:0]         out_col,
  output logic [5:0]         out_row,
  output logic signed [11:0] out_x,
  output logic signed [11:0] out_y,
  output logic [9:0]         out_width,
  output logic [9:0]         out_height,
  output logic               out_last
);

  ldsl_cmd_t cmd;  // sequencer commands
  ldsl_sts_t sts;  // count, mode and drain position back to the sequencer

  ldsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ldsl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_sprite_id  (in_sprite_id),
    .in_draw_layer (in_draw_layer),
    .in_sheet_col  (in_sheet_col),
    .in_sheet_row  (in_sheet_row),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_width      (in_width),
    .in_height     (in_height),
    .out_status    (out_status),
    .out_sprite    (out_sprite),
    .out_layer     (out_layer),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_width     (out_width),
    .out_height    (out_height),
    .out_last      (out_last)
  );

endmodule
